### sv/sound_slot_pool_with_eviction_assert.svh
// assertion macros for the sound slot pool
`ifndef SOUND_SLOT_POOL_WITH_EVICTION_ASSERT_SVH
`define SOUND_SLOT_POOL_WITH_EVICTION_ASSERT_SVH

// checked on every edge outside reset
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ssp_pkg.sv
// types, constants and helpers shared by the sound slot pool
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CD_W = 16;
  localparam int POS_W = 96;
  localparam int SLOT_OUT_W = 4;
  localparam logic [CD_W-1:0] CD_TOP = 16'hFFFF;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;

  localparam logic [1:0] EV_STOP = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] duration;
    logic [15:0] sound_id;
  } in_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [SLOT_OUT_W-1:0] slot;
    logic [15:0]           out_sound_id;
    logic [31:0]           out_x;
    logic [31:0]           out_y;
    logic [31:0]           out_z;
    logic                  last;
  } out_t;

  function automatic out_t make_res(input logic [1:0] ev, input logic [IDX_W-1:0] idx,
                                    input logic [15:0] sid, input logic [POS_W-1:0] pos,
                                    input logic fin);
    logic [IDX_W+SLOT_OUT_W-1:0] wide;
    out_t r;
    wide = {{SLOT_OUT_W{1'b0}}, idx};
    r.event_res = ev;
    r.slot = wide[SLOT_OUT_W-1:0];
    r.out_sound_id = sid;
    r.out_x = pos[95:64];
    r.out_y = pos[63:32];
    r.out_z = pos[31:0];
    r.last = fin;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ssp_ram.sv
// simple dual-port synchronous ram, one write and one registered read
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/sound_slot_pool_with_eviction.sv
// sound slot pool with least-remaining eviction, top level
//
//   channel   handshake                 word
//   command   start / busy              req   (ssp_pkg::in_t)
//   result    res_valid strobe          res   (ssp_pkg::out_t)
//
// clear and unused commands: done word on the next cycle, busy stays low
// tick: one slot per cycle through the countdown ram
// play: same scan, then optional stop and the start word
// synchronous reset clears all countdowns at once through per-slot valid flags
// result words come one per cycle at most and cannot be held off
`timescale 1ns / 1ps
`default_nettype none

`include "sound_slot_pool_with_eviction_assert.svh"

module sound_slot_pool_with_eviction (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire ssp_pkg::in_t req,
  output logic              res_valid,
  output ssp_pkg::out_t     res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_END,
    S_PLAY,
    S_PLAY_END,
    S_START
  } state_t;

  state_t                          state;
  ssp_pkg::in_t                    cur;
  logic [ssp_pkg::CNT_W-1:0]       cnt;
  logic                            p_vld;
  logic [ssp_pkg::IDX_W-1:0]       p_idx;
  logic [ssp_pkg::SLOTS-1:0]       valid;
  logic                            rd_valid;
  logic                            found;
  logic [ssp_pkg::IDX_W-1:0]       pick;
  logic [ssp_pkg::CD_W-1:0]        least;
  logic [ssp_pkg::IDX_W-1:0]       best;
  logic [ssp_pkg::POS_W-1:0]       best_pos;
  logic [ssp_pkg::IDX_W-1:0]       target;

  logic                            scan;
  logic                            issue;
  logic                            scan_end;
  logic [ssp_pkg::IDX_W-1:0]       raddr;
  logic [ssp_pkg::CD_W-1:0]        cd_rdata;
  logic [ssp_pkg::CD_W-1:0]        cd_eff;
  logic [ssp_pkg::POS_W-1:0]       pos_rdata;
  logic                            cd_we;
  logic [ssp_pkg::IDX_W-1:0]       cd_waddr;
  logic [ssp_pkg::CD_W-1:0]        cd_wdata;
  logic                            pos_we;
  logic [ssp_pkg::POS_W-1:0]       pos_wdata;

  assign busy      = (state != S_IDLE);
  assign scan      = (state == S_TICK) || (state == S_PLAY);
  assign issue     = scan && (cnt != ssp_pkg::CNT_W'(ssp_pkg::SLOTS));
  assign scan_end  = (cnt == ssp_pkg::CNT_W'(ssp_pkg::SLOTS)) && p_vld;
  assign raddr     = cnt[ssp_pkg::IDX_W-1:0];
  assign cd_eff    = rd_valid ? cd_rdata : '0;
  assign pos_we    = (state == S_START);
  assign pos_wdata = {cur.pos_x, cur.pos_y, cur.pos_z};

  always_comb begin
    cd_we    = 1'b0;
    cd_waddr = p_idx;
    cd_wdata = cd_eff - ssp_pkg::CD_W'(1);
    if (state == S_TICK && p_vld && cd_eff != '0) begin
      cd_we = 1'b1;
    end else if (state == S_START) begin
      cd_we    = 1'b1;
      cd_waddr = target;
      cd_wdata = cur.duration;
    end
  end

  ssp_ram #(
    .DEPTH(ssp_pkg::SLOTS),
    .WIDTH(ssp_pkg::CD_W)
  ) u_cd_ram (
    .clk  (clk),
    .we   (cd_we),
    .waddr(cd_waddr),
    .wdata(cd_wdata),
    .raddr(raddr),
    .rdata(cd_rdata)
  );

  ssp_ram #(
    .DEPTH(ssp_pkg::SLOTS),
    .WIDTH(ssp_pkg::POS_W)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(target),
    .wdata(pos_wdata),
    .raddr(raddr),
    .rdata(pos_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      valid     <= '0;
      cnt       <= '0;
      p_vld     <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      p_vld     <= issue;
      p_idx     <= raddr;
      rd_valid  <= issue ? valid[raddr] : 1'b0;
      if (issue) begin
        cnt <= cnt + ssp_pkg::CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= req;
            cnt   <= '0;
            found <= 1'b0;
            least <= ssp_pkg::CD_TOP;
            best  <= '0;
            priority if (req.cmd == ssp_pkg::CMD_TICK) begin
              state <= S_TICK;
            end else if (req.cmd == ssp_pkg::CMD_PLAY) begin
              state <= S_PLAY;
            end else begin
              if (req.cmd == ssp_pkg::CMD_CLEAR) begin
                valid <= '0;
              end
              res_valid <= 1'b1;
              res <= ssp_pkg::make_res(ssp_pkg::EV_DONE, '0, '0, '0, 1'b1);
            end
          end
        end
        S_TICK: begin
          if (p_vld && cd_eff == ssp_pkg::CD_W'(1)) begin
            res_valid <= 1'b1;
            res <= ssp_pkg::make_res(ssp_pkg::EV_STOP, p_idx, '0, pos_rdata, 1'b0);
          end
          if (scan_end) begin
            state <= S_TICK_END;
          end
        end
        S_TICK_END: begin
          res_valid <= 1'b1;
          res <= ssp_pkg::make_res(ssp_pkg::EV_DONE, '0, '0, '0, 1'b1);
          state <= S_IDLE;
        end
        S_PLAY: begin
          if (p_vld && !found) begin
            if (cd_eff == '0) begin
              found <= 1'b1;
              pick  <= p_idx;
            end else if (cd_eff < least || p_idx == '0) begin
              least    <= cd_eff;
              best     <= p_idx;
              best_pos <= pos_rdata;
            end
          end
          if (scan_end) begin
            state <= S_PLAY_END;
          end
        end
        S_PLAY_END: begin
          if (found) begin
            target <= pick;
          end else begin
            target    <= best;
            res_valid <= 1'b1;
            res <= ssp_pkg::make_res(ssp_pkg::EV_STOP, best, '0, best_pos, 1'b0);
          end
          state <= S_START;
        end
        S_START: begin
          valid[target] <= 1'b1;
          res_valid <= 1'b1;
          res <= ssp_pkg::make_res(ssp_pkg::EV_START, target, cur.sound_id, pos_wdata, 1'b1);
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SSP_ASSERT(a_play_goes_busy, (start && !busy && req.cmd == ssp_pkg::CMD_PLAY) |=> busy, "play not taken")
  `SSP_ASSERT(a_done_is_last, (res_valid && res.event_res == ssp_pkg::EV_DONE) |-> res.last, "done word not last")
  `SSP_ASSERT(a_fall_with_last, $fell(busy) |-> (res_valid && res.last), "busy dropped without last word")
  `SSP_ASSERT_ALWAYS(a_no_word_in_reset, rst |=> !res_valid, "result word out of reset")

endmodule

`default_nettype wire
